// ----- hw/rtl/hagg_pkg.sv -----
// ----------------------------------------------------------------------------
// hagg_pkg
// Shared types and constants for the histogram aggregator.
// ----------------------------------------------------------------------------
package hagg_pkg;

  localparam int MAX_BOUNDS_DEF = 7;
  localparam int SAMPLE_W       = 32;
  localparam int BOUND_W        = 32;
  localparam int COUNT_W        = 32;
  localparam int SUM_W          = 64;
  localparam int IDX_W          = 3;
  localparam int NUM_SLOTS      = 8;
  localparam int KIND_W         = 2;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 232;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_BOUND_COUNT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOUND_FIRST = 3'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD = 2'd0,
    KIND_CKPT   = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  // Classified request handed from front to back
  typedef struct packed {
    kind_t                       kind;
    logic [IDX_W-1:0]            idx;
    logic signed [SAMPLE_W-1:0]  sample;
  } qentry_t;

  typedef struct packed {
    logic [IDX_W-1:0]           bucket_index;
    logic [COUNT_W-1:0]         bucket_total;
    logic signed [SUM_W-1:0]    running_sum;
    logic [COUNT_W-1:0]         sample_total;
    logic signed [SUM_W-1:0]    saved_sum;
    logic [COUNT_W-1:0]         saved_count;
  } result_t;

endpackage

// ----- hw/rtl/histogram_aggregator.sv -----
// ----------------------------------------------------------------------------
// histogram_aggregator
// Explicit-boundary histogram engine with running sum and checkpoint.
// ----------------------------------------------------------------------------
// Every accepted request (record, checkpoint or read; kind 3 is taken and
// dropped) yields one result. The block sustains one request per clock while
// out_tready stays high: the front compares the sample against all boundaries
// in parallel and queues the request, the back does the bucket counter and
// 64-bit sum update and registers the result. A request goes to the queue,
// then to the output register that drives out_tvalid when the back takes it.
// While out_tready is low the output register and the 2-entry queue still
// take up to three requests; once the queue is full in_tready drops and rises
// again at the edge where the back takes the next queued request.
// Write configuration only while idle.
// ----------------------------------------------------------------------------
module histogram_aggregator #(
  parameter int MAX_BOUNDS = hagg_pkg::MAX_BOUNDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input request stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [hagg_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] sample_value, [34:32] bucket_select
  input  logic [hagg_pkg::KIND_W-1:0]         in_tuser,   // [1:0] kind
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [hagg_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [2:0] bucket_index, [34:3] bucket_total,
                                                          // [98:35] running_sum, [130:99] sample_total,
                                                          // [194:131] saved_sum_out,
                                                          // [226:195] saved_count_out
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [hagg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [hagg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [hagg_pkg::IDX_W-1:0]                  bound_count_r;
  logic [MAX_BOUNDS-1:0][hagg_pkg::BOUND_W-1:0] bounds_r;

  logic               push, q_full, pop, head_valid;
  hagg_pkg::qentry_t  push_entry, head;
  hagg_pkg::result_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_count_r <= '0;
      bounds_r      <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_addr == hagg_pkg::CFG_BOUND_COUNT) begin
        bound_count_r <= cfg_wdata[hagg_pkg::IDX_W-1:0];
      end
      // boundaries beyond MAX_BOUNDS are never used, so they are not stored
      for (int i = 0; i < MAX_BOUNDS; i++) begin
        if (cfg_addr == hagg_pkg::CFG_BOUND_FIRST + hagg_pkg::CFG_ADDR_W'(i)) begin
          bounds_r[i] <= cfg_wdata[hagg_pkg::BOUND_W-1:0];
        end
      end
    end
  end

  hagg_front #(
    .MAX_BOUNDS (MAX_BOUNDS)
  ) u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_kind     (in_tuser),
    .in_sample   (in_tdata[hagg_pkg::SAMPLE_W-1:0]),
    .in_select   (in_tdata[hagg_pkg::SAMPLE_W +: hagg_pkg::IDX_W]),
    .bound_count (bound_count_r),
    .bounds      (bounds_r),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (q_full)
  );

  hagg_queue #(
    .DEPTH (hagg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  hagg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {5'b0, res.saved_count, res.saved_sum, res.sample_total,
                      res.running_sum, res.bucket_total, res.bucket_index};

endmodule

// ----- hw/rtl/hagg_front.sv -----
// ----------------------------------------------------------------------------
// hagg_front
// Accepts requests, finds the bucket of a record and pushes the classified
// request into the queue. Unused kind codes are taken and dropped.
// ----------------------------------------------------------------------------
module hagg_front #(
  parameter int MAX_BOUNDS = hagg_pkg::MAX_BOUNDS_DEF
) (
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  input  logic [hagg_pkg::KIND_W-1:0]                   in_kind,
  input  logic [hagg_pkg::SAMPLE_W-1:0]                 in_sample,
  input  logic [hagg_pkg::IDX_W-1:0]                    in_select,
  input  logic [hagg_pkg::IDX_W-1:0]                    bound_count,
  input  logic [MAX_BOUNDS-1:0][hagg_pkg::BOUND_W-1:0]  bounds,
  output logic                                          push,
  output hagg_pkg::qentry_t                             push_entry,
  input  logic                                          q_full
);

  localparam logic [hagg_pkg::IDX_W-1:0] MAX_B = hagg_pkg::IDX_W'(MAX_BOUNDS);

  logic [hagg_pkg::IDX_W-1:0] used;
  logic [hagg_pkg::IDX_W-1:0] hit_idx;
  logic                       known;

  assign used      = (bound_count > MAX_B) ? MAX_B : bound_count;
  assign in_tready = !q_full;

  // First boundary in index order above the sample wins; walk down so the
  // lowest match is the last assignment.
  always_comb begin
    hit_idx = used;
    for (int i = MAX_BOUNDS - 1; i >= 0; i--) begin
      if ((hagg_pkg::IDX_W'(i) < used) && ($signed(in_sample) < $signed(bounds[i]))) begin
        hit_idx = hagg_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    known             = 1'b1;
    push_entry.kind   = hagg_pkg::kind_t'(in_kind);
    push_entry.sample = in_sample;
    push_entry.idx    = '0;
    case (in_kind)
      hagg_pkg::KIND_RECORD: begin
        push_entry.idx = hit_idx;
      end
      hagg_pkg::KIND_CKPT: begin
        push_entry.idx = '0;
      end
      hagg_pkg::KIND_READ: begin
        push_entry.idx = in_select;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign push = in_tvalid && in_tready && known;

endmodule

// ----- hw/rtl/hagg_queue.sv -----
// ----------------------------------------------------------------------------
// hagg_queue
// Short FIFO between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module hagg_queue #(
  parameter int DEPTH = hagg_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hagg_pkg::qentry_t  push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output hagg_pkg::qentry_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hagg_pkg::qentry_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- hw/rtl/hagg_back.sv -----
// ----------------------------------------------------------------------------
// hagg_back
// Executes queued requests against the bucket counters, the running sum and
// count and the checkpoint registers; holds the result in an output register.
// ----------------------------------------------------------------------------
module hagg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  hagg_pkg::qentry_t  head,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_ready,
  output hagg_pkg::result_t  res
);

  localparam logic [hagg_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  logic [hagg_pkg::COUNT_W-1:0]      bucket_cnt_r [hagg_pkg::NUM_SLOTS];
  logic signed [hagg_pkg::SUM_W-1:0] sum_acc_r, sum_acc_nxt;
  logic [hagg_pkg::COUNT_W-1:0]      count_acc_r, count_acc_nxt;
  logic signed [hagg_pkg::SUM_W-1:0] saved_sum_r, saved_sum_nxt;
  logic [hagg_pkg::COUNT_W-1:0]      saved_count_r, saved_count_nxt;
  logic                              res_valid_r, res_valid_nxt;
  hagg_pkg::result_t                 res_r, res_nxt;
  logic [hagg_pkg::COUNT_W-1:0]      cur_cnt, inc_cnt;
  logic                              bucket_we;

  assign pop       = head_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign cur_cnt = bucket_cnt_r[head.idx];
  assign inc_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;

  always_comb begin
    sum_acc_nxt     = sum_acc_r;
    count_acc_nxt   = count_acc_r;
    saved_sum_nxt   = saved_sum_r;
    saved_count_nxt = saved_count_r;
    bucket_we       = 1'b0;
    res_nxt         = res_r;
    res_valid_nxt   = res_valid_r && !res_ready;
    if (pop) begin
      res_valid_nxt        = 1'b1;
      res_nxt.bucket_index = '0;
      res_nxt.bucket_total = '0;
      case (head.kind)
        hagg_pkg::KIND_RECORD: begin
          bucket_we            = 1'b1;
          res_nxt.bucket_index = head.idx;
          res_nxt.bucket_total = inc_cnt;
          sum_acc_nxt          = sum_acc_r + hagg_pkg::SUM_W'(head.sample);
          count_acc_nxt        = (count_acc_r == COUNT_MAX) ? count_acc_r
                                                            : count_acc_r + 1'b1;
        end
        hagg_pkg::KIND_CKPT: begin
          saved_sum_nxt   = sum_acc_r;
          saved_count_nxt = count_acc_r;
          sum_acc_nxt     = '0;
          count_acc_nxt   = '0;
        end
        hagg_pkg::KIND_READ: begin
          res_nxt.bucket_index = head.idx;
          res_nxt.bucket_total = cur_cnt;
        end
        default: begin
          res_valid_nxt = 1'b0;
        end
      endcase
      res_nxt.running_sum  = sum_acc_nxt;
      res_nxt.sample_total = count_acc_nxt;
      res_nxt.saved_sum    = saved_sum_nxt;
      res_nxt.saved_count  = saved_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hagg_pkg::NUM_SLOTS; i++) begin
        bucket_cnt_r[i] <= '0;
      end
      sum_acc_r     <= '0;
      count_acc_r   <= '0;
      saved_sum_r   <= '0;
      saved_count_r <= '0;
      res_valid_r   <= 1'b0;
    end else begin
      if (bucket_we) begin
        bucket_cnt_r[head.idx] <= inc_cnt;
      end
      sum_acc_r     <= sum_acc_nxt;
      count_acc_r   <= count_acc_nxt;
      saved_sum_r   <= saved_sum_nxt;
      saved_count_r <= saved_count_nxt;
      res_valid_r   <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

`ifndef SYNTHESIS
  // a checkpoint leaves the running pair clear and reports no bucket
  a_ckpt_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.kind == hagg_pkg::KIND_CKPT) |=>
      (sum_acc_r == '0 && count_acc_r == '0 && res_r.bucket_total == '0))
    else $error("checkpoint did not clear running sum/count");

  // a record always leaves nonzero bucket and sample counts in the result
  a_record_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.kind == hagg_pkg::KIND_RECORD) |=>
      (res_valid_r && res_r.bucket_total != '0 && res_r.sample_total != '0))
    else $error("record produced a zero count");

  // a read returns the stored counter of the requested bucket
  a_read_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.kind == hagg_pkg::KIND_READ) |=>
      (res_r.bucket_index == $past(head.idx) &&
       res_r.bucket_total == bucket_cnt_r[$past(head.idx)]))
    else $error("read result does not match bucket counter");
`endif

endmodule

// ----- tb/tb_histogram_aggregator.sv -----
// ----------------------------------------------------------------------------
// tb_histogram_aggregator
// Self-checking bench for the explicit-boundary histogram engine.
// A short table of requests covers reset state, sample extremes, unsorted and
// saturated boundary sets and the unused kind. Random phases follow, each with
// freshly written boundaries. Every result is compared field by field against
// typed-in values or a local model of bucket counters, sums and checkpoints.
// ----------------------------------------------------------------------------
module tb_histogram_aggregator;

  localparam logic [hagg_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int WDOG_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_REQS    = 50;
  localparam int DIR_ROWS      = 25;

  typedef struct packed {
    logic [hagg_pkg::IDX_W-1:0]   idx;
    logic [hagg_pkg::COUNT_W-1:0] hits;
    logic [hagg_pkg::SUM_W-1:0]   rsum;
    logic [hagg_pkg::COUNT_W-1:0] rcnt;
    logic [hagg_pkg::SUM_W-1:0]   ssum;
    logic [hagg_pkg::COUNT_W-1:0] scnt;
  } hist_res_t;

  // typed = 1: the row carries its own expected result
  typedef struct packed {
    logic              typed;
    hist_res_t         want;
  } req_tag_t;

  typedef struct packed {
    logic [1:0]                    setting;
    logic [hagg_pkg::KIND_W-1:0]   kind;
    logic [hagg_pkg::SAMPLE_W-1:0] sample;
    logic [hagg_pkg::IDX_W-1:0]    sel;
    logic                          typed;
    hist_res_t                     want;
  } dir_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [hagg_pkg::IN_TDATA_W-1:0]  in_tdata = '0;   // [31:0] sample_value, [34:32] bucket_select
  logic [hagg_pkg::KIND_W-1:0]      in_tuser = '0;   // [1:0] kind
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [hagg_pkg::OUT_TDATA_W-1:0] out_tdata;       // [2:0] bucket_index, [34:3] bucket_total,
                                                     // [98:35] running_sum, [130:99] sample_total,
                                                     // [194:131] saved_sum_out,
                                                     // [226:195] saved_count_out
  logic                             cfg_wr_en = 1'b0;
  logic [hagg_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [hagg_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  histogram_aggregator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state
  logic [hagg_pkg::IDX_W-1:0]   n_bounds = '0;
  logic [hagg_pkg::BOUND_W-1:0] bnd [hagg_pkg::MAX_BOUNDS_DEF] = '{default: '0};
  logic [hagg_pkg::COUNT_W-1:0] bin_cnt [hagg_pkg::NUM_SLOTS] = '{default: '0};
  logic [hagg_pkg::SUM_W-1:0]   run_sum = '0;
  logic [hagg_pkg::COUNT_W-1:0] run_cnt = '0;
  logic [hagg_pkg::SUM_W-1:0]   saved_sum = '0;
  logic [hagg_pkg::COUNT_W-1:0] saved_cnt = '0;

  hist_res_t results_due [$];
  req_tag_t  req_tags [$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        snd_idle_pct = 34;
  int        rcv_idle_pct = 74;

  function automatic bit advance_histogram(input logic [hagg_pkg::KIND_W-1:0] k,
                                           input logic [hagg_pkg::SAMPLE_W-1:0] s,
                                           input logic [hagg_pkg::IDX_W-1:0] sel,
                                           output hist_res_t r);
    int used;
    logic [hagg_pkg::IDX_W-1:0] hit;
    r = '0;
    used = (int'(n_bounds) > hagg_pkg::MAX_BOUNDS_DEF) ? hagg_pkg::MAX_BOUNDS_DEF
                                                       : int'(n_bounds);
    case (k)
      hagg_pkg::KIND_RECORD: begin
        // first boundary in index order above the sample wins, else overflow
        hit = hagg_pkg::IDX_W'(used);
        for (int i = used - 1; i >= 0; i--)
          if ($signed(s) < $signed(bnd[i])) hit = hagg_pkg::IDX_W'(i);
        if (bin_cnt[hit] != '1) bin_cnt[hit] = bin_cnt[hit] + 1'b1;
        run_sum = run_sum + {{(hagg_pkg::SUM_W-hagg_pkg::SAMPLE_W){s[hagg_pkg::SAMPLE_W-1]}}, s};
        if (run_cnt != '1) run_cnt = run_cnt + 1'b1;
        r.idx  = hit;
        r.hits = bin_cnt[hit];
      end
      hagg_pkg::KIND_CKPT: begin
        saved_sum = run_sum;
        saved_cnt = run_cnt;
        run_sum   = '0;
        run_cnt   = '0;
      end
      hagg_pkg::KIND_READ: begin
        r.idx  = sel;
        r.hits = bin_cnt[sel];
      end
      default: return 1'b0;
    endcase
    r.rsum = run_sum;
    r.rcnt = run_cnt;
    r.ssum = saved_sum;
    r.scnt = saved_cnt;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // scoreboard and watchdog
  hist_res_t mon_pred, mon_got, mon_want;
  req_tag_t  mon_tag;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        mon_got = '{out_tdata[2:0], out_tdata[34:3], out_tdata[98:35],
                    out_tdata[130:99], out_tdata[194:131], out_tdata[226:195]};
        if (results_due.size() == 0) begin
          $error("result with no request pending: 0x%0h", out_tdata);
          mismatches++;
        end else begin
          mon_want = results_due.pop_front();
          check_field("bucket_index", 64'(mon_want.idx), 64'(mon_got.idx));
          check_field("bucket_total", 64'(mon_want.hits), 64'(mon_got.hits));
          check_field("running_sum", mon_want.rsum, mon_got.rsum);
          check_field("sample_total", 64'(mon_want.rcnt), 64'(mon_got.rcnt));
          check_field("saved_sum_out", mon_want.ssum, mon_got.ssum);
          check_field("saved_count_out", 64'(mon_want.scnt), 64'(mon_got.scnt));
        end
      end
      if (in_tvalid && in_tready) begin
        mon_tag = (req_tags.size() != 0) ? req_tags.pop_front() : '0;
        if (advance_histogram(in_tuser, in_tdata[31:0], in_tdata[34:32], mon_pred))
          results_due.push_back(mon_tag.typed ? mon_tag.want : mon_pred);
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("histogram_aggregator verification failed");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [hagg_pkg::KIND_W-1:0] k,
                              input logic [hagg_pkg::SAMPLE_W-1:0] s,
                              input logic [hagg_pkg::IDX_W-1:0] sel, input logic typed,
                              input hist_res_t want);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    req_tags.push_back('{typed, want});
    in_tvalid <= 1'b1;
    in_tdata  <= {{(hagg_pkg::IN_TDATA_W-hagg_pkg::SAMPLE_W-hagg_pkg::IDX_W){1'b0}}, sel, s};
    in_tuser  <= k;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // holds off the sender until every result is back, plus pipeline slack for
  // unused-kind requests that leave no result behind
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0 || req_tags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_bounds(input logic [hagg_pkg::IDX_W-1:0] n,
                                input logic [hagg_pkg::BOUND_W-1:0] b [hagg_pkg::MAX_BOUNDS_DEF]);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= hagg_pkg::CFG_BOUND_COUNT;
    cfg_wdata <= hagg_pkg::CFG_DATA_W'(n);
    n_bounds = n;
    for (int i = 0; i < hagg_pkg::MAX_BOUNDS_DEF; i++) begin
      @(posedge clk);
      cfg_addr  <= hagg_pkg::CFG_BOUND_FIRST + hagg_pkg::CFG_ADDR_W'(i);
      cfg_wdata <= b[i];
      bnd[i] = b[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  logic [hagg_pkg::IDX_W-1:0]   dir_nb [4] = '{3'd0, 3'd7, 3'd3, 3'd0};
  logic [hagg_pkg::BOUND_W-1:0] dir_bounds [4][hagg_pkg::MAX_BOUNDS_DEF] = '{
    '{default: 32'd0},
    '{32'h8000_0000, -32'sd10, 32'd0, 32'd10, 32'd100, 32'd1000, 32'h7FFF_FFFF},
    '{32'd100, -32'sd100, 32'd50, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0},
    '{32'd1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5, 32'd6, 32'd7, 32'd8}
  };

  dir_row_t dir_tab [DIR_ROWS] = '{
    // reset values, expectations typed in
    '{2'd0, hagg_pkg::KIND_READ,   32'd0,         3'd0, 1'b1,
      '{3'd0, 32'd0, 64'd0, 32'd0, 64'd0, 32'd0}},
    '{2'd0, hagg_pkg::KIND_READ,   32'd0,         3'd7, 1'b1,
      '{3'd7, 32'd0, 64'd0, 32'd0, 64'd0, 32'd0}},
    '{2'd0, hagg_pkg::KIND_CKPT,   32'd0,         3'd0, 1'b1,
      '{3'd0, 32'd0, 64'd0, 32'd0, 64'd0, 32'd0}},
    '{2'd0, hagg_pkg::KIND_RECORD, 32'd5,         3'd0, 1'b1,
      '{3'd0, 32'd1, 64'd5, 32'd1, 64'd0, 32'd0}},
    '{2'd0, hagg_pkg::KIND_RECORD, 32'h8000_0000, 3'd7, 1'b1,
      '{3'd0, 32'd2, 64'hFFFF_FFFF_8000_0005, 32'd2, 64'd0, 32'd0}},
    '{2'd0, hagg_pkg::KIND_RECORD, 32'h7FFF_FFFF, 3'd5, 1'b1,
      '{3'd0, 32'd3, 64'd4, 32'd3, 64'd0, 32'd0}},
    '{2'd0, KIND_UNUSED,           32'hFFFF_FFFF, 3'd7, 1'b0, '0},
    '{2'd0, hagg_pkg::KIND_CKPT,   32'd0,         3'd0, 1'b1,
      '{3'd0, 32'd0, 64'd0, 32'd0, 64'd4, 32'd3}},
    '{2'd0, hagg_pkg::KIND_READ,   32'd0,         3'd0, 1'b1,
      '{3'd0, 32'd3, 64'd0, 32'd0, 64'd4, 32'd3}},
    // sorted boundaries, lowest one at the minimum, highest at the maximum
    '{2'd1, hagg_pkg::KIND_RECORD, 32'h8000_0000, 3'd0, 1'b0, '0},
    '{2'd1, hagg_pkg::KIND_RECORD, -32'sd11,      3'd0, 1'b0, '0},
    '{2'd1, hagg_pkg::KIND_RECORD, 32'd0,         3'd0, 1'b0, '0},
    '{2'd1, hagg_pkg::KIND_RECORD, 32'h7FFF_FFFF, 3'd0, 1'b0, '0},
    '{2'd1, hagg_pkg::KIND_RECORD, 32'h7FFF_FFFE, 3'd0, 1'b0, '0},
    '{2'd1, hagg_pkg::KIND_READ,   32'd0,         3'd7, 1'b0, '0},
    '{2'd1, hagg_pkg::KIND_READ,   32'd0,         3'd1, 1'b0, '0},
    // unsorted boundaries, three in use
    '{2'd2, hagg_pkg::KIND_RECORD, 32'd60,        3'd0, 1'b0, '0},
    '{2'd2, hagg_pkg::KIND_RECORD, -32'sd150,     3'd0, 1'b0, '0},
    '{2'd2, hagg_pkg::KIND_RECORD, 32'd200,       3'd0, 1'b0, '0},
    '{2'd2, hagg_pkg::KIND_RECORD, 32'd75,        3'd0, 1'b0, '0},
    '{2'd2, hagg_pkg::KIND_READ,   32'd0,         3'd5, 1'b0, '0},
    '{2'd2, hagg_pkg::KIND_CKPT,   32'd0,         3'd0, 1'b0, '0},
    // no boundaries in use: everything lands in bucket 0
    '{2'd3, hagg_pkg::KIND_RECORD, -32'sd5,       3'd0, 1'b0, '0},
    '{2'd3, hagg_pkg::KIND_RECORD, 32'h7FFF_FFFF, 3'd0, 1'b0, '0},
    '{2'd3, hagg_pkg::KIND_READ,   32'd0,         3'd0, 1'b0, '0}
  };

  initial begin
    int                            cur_setting;
    int                            counted;
    int                            mode;
    int                            pick;
    logic [hagg_pkg::IDX_W-1:0]    nset;
    logic [hagg_pkg::BOUND_W-1:0]  bset [hagg_pkg::MAX_BOUNDS_DEF];
    logic [hagg_pkg::KIND_W-1:0]   k;
    logic [hagg_pkg::SAMPLE_W-1:0] s;

    cur_setting = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (int'(dir_tab[r].setting) != cur_setting) begin
        wait_for_results();
        cur_setting = int'(dir_tab[r].setting);
        foreach (bset[i]) bset[i] = dir_bounds[cur_setting][i];
        program_bounds(dir_nb[cur_setting], bset);
      end
      send_request(dir_tab[r].kind, dir_tab[r].sample, dir_tab[r].sel,
                   dir_tab[r].typed, dir_tab[r].want);
    end

    for (int regime = 0; regime < 3; regime++) begin
      snd_idle_pct = (regime == 0) ? 34 : (regime == 1) ? 74 : 0;
      rcv_idle_pct = (regime == 0) ? 74 : (regime == 1) ? 34 : 0;
      for (int ph = 0; ph < 5; ph++) begin
        wait_for_results();
        nset = hagg_pkg::IDX_W'($urandom_range(7));
        mode = $urandom_range(3);
        bset[0] = hagg_pkg::BOUND_W'(int'($urandom_range(2000)) - 1000);
        for (int i = 0; i < hagg_pkg::MAX_BOUNDS_DEF; i++) begin
          case (mode)
            0: bset[i] = $urandom;
            1: if (i > 0) bset[i] = bset[i-1] + hagg_pkg::BOUND_W'($urandom_range(1, 400));
            2: bset[i] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: bset[i] = hagg_pkg::BOUND_W'(int'($urandom_range(100)) - 50);
          endcase
        end
        program_bounds(nset, bset);

        counted = 0;
        while (counted < PHASE_REQS) begin
          pick = $urandom_range(99);
          k = (pick < 58) ? hagg_pkg::KIND_RECORD : (pick < 70) ? hagg_pkg::KIND_CKPT :
              (pick < 95) ? hagg_pkg::KIND_READ : KIND_UNUSED;
          case ($urandom_range(9))
            0: s = 32'h8000_0000;
            1: s = 32'h7FFF_FFFF;
            2, 3, 4: s = bnd[$urandom_range(hagg_pkg::MAX_BOUNDS_DEF - 1)]
                         + hagg_pkg::SAMPLE_W'($urandom_range(2)) - 1'b1;
            5, 6: s = hagg_pkg::SAMPLE_W'(int'($urandom_range(400)) - 200);
            default: s = $urandom;
          endcase
          send_request(k, s, hagg_pkg::IDX_W'($urandom_range(7)), 1'b0, '0);
          if (k != KIND_UNUSED) counted++;
          // occasional full drain in mid-phase
          if ($urandom_range(39) == 0) wait_for_results();
        end
      end
    end

    wait_for_results();
    if (mismatches == 0)
      $display("histogram_aggregator verification clean");
    else
      $display("histogram_aggregator verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/hagg_pkg.sv
hw/rtl/hagg_front.sv
hw/rtl/hagg_queue.sv
hw/rtl/hagg_back.sv
hw/rtl/histogram_aggregator.sv
tb/tb_histogram_aggregator.sv
